// ===== hw/rtl/llgq_pkg.sv =====
// ============================================================================
// llgq_pkg: shared types and constants of the lock grant queue
// Request and result payloads, result kinds, controller states and the
// command and status groups between the controller and the datapath.
// ============================================================================
package llgq_pkg;

    localparam int OWNER_DEPTH_DEF  = 8;
    localparam int WAITER_DEPTH_DEF = 16;
    localparam int MAX_RESULTS      = 16;
    localparam int PC_W             = $clog2(MAX_RESULTS + 1);
    localparam int COMPAT_W         = 16;

    localparam logic [COMPAT_W-1:0] COMPAT_RESET   = 16'd4415;
    localparam logic [1:0]          LOCK_MODE_NONE = 2'd0;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        KIND_GRANTED   = 3'd0,
        KIND_QUEUED    = 3'd1,
        KIND_REJECTED  = 3'd2,
        KIND_RELEASED  = 3'd3,
        KIND_PROMOTED  = 3'd4,
        KIND_NOT_OWNER = 3'd5
    } t_kind;

    typedef struct packed {
        logic        op;
        logic [15:0] txn_id;
        logic [1:0]  req_mode;
    } t_req;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] promoted_txn;
        logic [1:0]  promoted_mode;
        logic [1:0]  lock_mode;
        logic [3:0]  owner_count;
        logic [4:0]  waiter_count;
        logic        last;
    } t_rsp;

    typedef struct packed {
        logic [15:0] txn;
        logic [1:0]  mode;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACQ,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_REL_END,
        S_PRO_RD,
        S_PRO_CHK
    } t_state;

    typedef struct packed {
        logic load;
        logic acq;
        logic scan_chk;
        logic rel_end;
        logic pro_chk;
    } t_cmd;

    typedef struct packed {
        logic scan_more;
        logic found;
        logic mode_changed;
        logic pro_go;
    } t_sts;

    function automatic logic compat_ok(input logic [COMPAT_W-1:0] matrix,
                                       input logic [1:0] held,
                                       input logic [1:0] req);
        return matrix[{held, req}];
    endfunction

endpackage

// ===== hw/rtl/llgq_ram.sv =====
// ============================================================================
// llgq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module llgq_ram
    import llgq_pkg::*;
#(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = OWNER_DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/llgq_ctrl.sv =====
// ============================================================================
// llgq_ctrl: sequencing controller of the lock grant queue
// Steps a request through acquire, owner scan, release and promotion.
// ============================================================================
module llgq_ctrl
    import llgq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_op,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = (i_op == OP_RELEASE) ? S_SCAN_RD : S_ACQ;
                end
            end
            S_ACQ: begin
                n_state = S_IDLE;
            end
            S_SCAN_RD: begin
                n_state = i_sts.scan_more ? S_SCAN_CHK : S_REL_END;
            end
            S_SCAN_CHK: begin
                n_state = S_SCAN_RD;
            end
            S_REL_END: begin
                n_state = (i_sts.found && i_sts.mode_changed) ? S_PRO_RD : S_IDLE;
            end
            S_PRO_RD: begin
                n_state = S_PRO_CHK;
            end
            S_PRO_CHK: begin
                n_state = i_sts.pro_go ? S_PRO_RD : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_ACQ: begin
                o_cmd.acq = 1'b1;
            end
            S_SCAN_CHK: begin
                o_cmd.scan_chk = 1'b1;
            end
            S_REL_END: begin
                o_cmd.rel_end = 1'b1;
            end
            S_PRO_CHK: begin
                o_cmd.pro_chk = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/llgq_dp.sv =====
// ============================================================================
// llgq_dp: datapath of the lock grant queue
// Owner table and waiter FIFO memories, counters, held mode, compatibility
// matrix and the result register.
// ============================================================================
module llgq_dp
    import llgq_pkg::*;
#(
    parameter int OWNER_DEPTH  = OWNER_DEPTH_DEF,
    parameter int WAITER_DEPTH = WAITER_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_req                i_req,
    input  logic                i_cfg_we,
    input  logic [COMPAT_W-1:0] i_cfg_data,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    output logic                o_rsp_valid,
    output t_rsp                o_rsp
);

    localparam int OA_W = (OWNER_DEPTH > 1) ? $clog2(OWNER_DEPTH) : 1;
    localparam int OC_W = $clog2(OWNER_DEPTH + 1);
    localparam int WA_W = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
    localparam int WC_W = $clog2(WAITER_DEPTH + 1);

    t_req                r_req,      n_req;
    logic [COMPAT_W-1:0] r_compat,   n_compat;
    logic [1:0]          r_held,     n_held;
    logic [OC_W-1:0]     r_own_cnt,  n_own_cnt;
    logic [WC_W-1:0]     r_wait_cnt, n_wait_cnt;
    logic [WA_W-1:0]     r_head,     n_head;
    logic [OC_W-1:0]     r_idx,      n_idx;
    logic                r_found,    n_found;
    logic [1:0]          r_acc,      n_acc;
    logic [PC_W-1:0]     r_pcnt,     n_pcnt;
    logic                r_pend,     n_pend;
    t_rsp                r_pend_rsp, n_pend_rsp;
    t_rsp                r_rsp,      n_rsp;
    logic                r_rsp_vld;

    logic            own_we;
    logic [OA_W-1:0] own_waddr;
    t_entry          own_wdata;
    t_entry          own_rdata;
    logic            wt_we;
    logic [WA_W-1:0] wt_waddr;
    t_entry          wt_wdata;
    t_entry          wt_rdata;

    logic [WC_W:0]   tail_sum;
    logic [WA_W-1:0] head_inc;
    logic [OC_W-1:0] idx_m1;
    logic            acq_ok;
    logic            pro_go;
    logic            e_emit;
    t_kind           e_kind;
    logic [15:0]     e_ptxn;
    logic [1:0]      e_pmode;
    logic            e_last;
    logic            use_pend;
    t_rsp            rsp_now;

    llgq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(OWNER_DEPTH)
    ) u_owner_ram (
        .i_clk  (i_clk),
        .i_we   (own_we),
        .i_waddr(own_waddr),
        .i_wdata(own_wdata),
        .i_raddr(r_idx[OA_W-1:0]),
        .o_rdata(own_rdata)
    );

    llgq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(WAITER_DEPTH)
    ) u_waiter_ram (
        .i_clk  (i_clk),
        .i_we   (wt_we),
        .i_waddr(wt_waddr),
        .i_wdata(wt_wdata),
        .i_raddr(r_head),
        .o_rdata(wt_rdata)
    );

    always_comb begin
        tail_sum = (WC_W + 1)'(r_head) + (WC_W + 1)'(r_wait_cnt);
        if (tail_sum >= (WC_W + 1)'(WAITER_DEPTH)) begin
            tail_sum = tail_sum - (WC_W + 1)'(WAITER_DEPTH);
        end
        wt_waddr = tail_sum[WA_W-1:0];
        head_inc = (r_head == WA_W'(WAITER_DEPTH - 1)) ? '0 : r_head + 1'b1;
        idx_m1   = r_idx - 1'b1;
    end

    assign acq_ok = compat_ok(r_compat, r_held, r_req.req_mode);
    assign pro_go = (r_pcnt < PC_W'(MAX_RESULTS)) && (r_wait_cnt != '0) &&
                    (r_own_cnt < OC_W'(OWNER_DEPTH)) &&
                    compat_ok(r_compat, r_held, wt_rdata.mode);

    always_comb begin
        n_req      = r_req;
        n_compat   = r_compat;
        n_held     = r_held;
        n_own_cnt  = r_own_cnt;
        n_wait_cnt = r_wait_cnt;
        n_head     = r_head;
        n_idx      = r_idx;
        n_found    = r_found;
        n_acc      = r_acc;
        n_pcnt     = r_pcnt;
        n_pend     = r_pend;
        n_pend_rsp = r_pend_rsp;
        own_we     = 1'b0;
        own_waddr  = r_own_cnt[OA_W-1:0];
        own_wdata  = wt_rdata;
        wt_we      = 1'b0;
        wt_wdata   = '{txn: r_req.txn_id, mode: r_req.req_mode};
        e_emit     = 1'b0;
        e_kind     = KIND_GRANTED;
        e_ptxn     = '0;
        e_pmode    = LOCK_MODE_NONE;
        e_last     = 1'b1;
        use_pend   = 1'b0;

        if (i_cfg_we) begin
            n_compat = i_cfg_data;
        end

        if (i_cmd.load) begin
            n_req   = i_req;
            n_idx   = '0;
            n_found = 1'b0;
            n_acc   = LOCK_MODE_NONE;
        end

        if (i_cmd.acq) begin
            e_emit = 1'b1;
            if (acq_ok) begin
                if (r_own_cnt == OC_W'(OWNER_DEPTH)) begin
                    e_kind = KIND_REJECTED;
                end else begin
                    own_we    = 1'b1;
                    own_wdata = '{txn: r_req.txn_id, mode: r_req.req_mode};
                    n_own_cnt = r_own_cnt + 1'b1;
                    if (r_req.req_mode != LOCK_MODE_NONE) begin
                        n_held = r_req.req_mode;
                    end
                    e_kind = KIND_GRANTED;
                end
            end else if (r_wait_cnt == WC_W'(WAITER_DEPTH)) begin
                e_kind = KIND_REJECTED;
            end else begin
                wt_we      = 1'b1;
                n_wait_cnt = r_wait_cnt + 1'b1;
                e_kind     = KIND_QUEUED;
            end
        end

        if (i_cmd.scan_chk) begin
            n_idx = r_idx + 1'b1;
            if (!r_found && (own_rdata.txn == r_req.txn_id)) begin
                n_found = 1'b1;
            end else begin
                if (own_rdata.mode != LOCK_MODE_NONE) begin
                    n_acc = own_rdata.mode;
                end
                if (r_found) begin
                    own_we    = 1'b1;
                    own_waddr = idx_m1[OA_W-1:0];
                    own_wdata = own_rdata;
                end
            end
        end

        if (i_cmd.rel_end) begin
            if (!r_found) begin
                e_emit = 1'b1;
                e_kind = KIND_NOT_OWNER;
            end else begin
                n_own_cnt = r_own_cnt - 1'b1;
                n_held    = r_acc;
                n_pcnt    = '0;
                n_pend    = 1'b0;
                if (r_acc == r_held) begin
                    e_emit = 1'b1;
                    e_kind = KIND_RELEASED;
                end
            end
        end

        if (i_cmd.pro_chk) begin
            if (pro_go) begin
                own_we     = 1'b1;
                own_wdata  = wt_rdata;
                n_own_cnt  = r_own_cnt + 1'b1;
                n_wait_cnt = r_wait_cnt - 1'b1;
                n_head     = head_inc;
                if (wt_rdata.mode != LOCK_MODE_NONE) begin
                    n_held = wt_rdata.mode;
                end
                n_pcnt  = r_pcnt + 1'b1;
                n_pend  = 1'b1;
                e_kind  = KIND_PROMOTED;
                e_ptxn  = wt_rdata.txn;
                e_pmode = wt_rdata.mode;
                e_last  = 1'b0;
            end else begin
                n_pend = 1'b0;
            end
            if (r_pend) begin
                e_emit   = 1'b1;
                use_pend = 1'b1;
            end else if (!pro_go) begin
                e_emit = 1'b1;
                e_kind = KIND_RELEASED;
            end
        end

        rsp_now = '{kind:          e_kind,
                    promoted_txn:  e_ptxn,
                    promoted_mode: e_pmode,
                    lock_mode:     n_held,
                    owner_count:   4'(n_own_cnt),
                    waiter_count:  5'(n_wait_cnt),
                    last:          e_last};

        if (i_cmd.pro_chk && pro_go) begin
            n_pend_rsp = rsp_now;
        end

        n_rsp = rsp_now;
        if (use_pend) begin
            n_rsp      = r_pend_rsp;
            n_rsp.last = !pro_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compat   <= COMPAT_RESET;
            r_held     <= LOCK_MODE_NONE;
            r_own_cnt  <= '0;
            r_wait_cnt <= '0;
            r_head     <= '0;
            r_pend     <= 1'b0;
            r_rsp_vld  <= 1'b0;
        end else begin
            r_compat   <= n_compat;
            r_held     <= n_held;
            r_own_cnt  <= n_own_cnt;
            r_wait_cnt <= n_wait_cnt;
            r_head     <= n_head;
            r_pend     <= n_pend;
            r_rsp_vld  <= e_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_idx      <= n_idx;
        r_found    <= n_found;
        r_acc      <= n_acc;
        r_pcnt     <= n_pcnt;
        r_pend_rsp <= n_pend_rsp;
        if (e_emit) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_sts.scan_more    = (r_idx < r_own_cnt);
    assign o_sts.found        = r_found;
    assign o_sts.mode_changed = (r_acc != r_held);
    assign o_sts.pro_go       = pro_go;
    assign o_rsp_valid        = r_rsp_vld;
    assign o_rsp              = r_rsp;

    a_acq_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.acq |=> r_rsp_vld)
        else $error("Acquire step did not produce a result.");

    a_not_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rel_end && !r_found) |=>
            (r_rsp_vld && (r_rsp.kind == KIND_NOT_OWNER) && r_rsp.last))
        else $error("Missing owner was not reported.");

    a_promote_moves_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pro_chk && pro_go) |=>
            ((r_own_cnt == $past(r_own_cnt) + 1'b1) &&
             (r_wait_cnt == $past(r_wait_cnt) - 1'b1)))
        else $error("Promotion did not move one waiter to the owners.");

    a_same_mode_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rel_end && r_found && (r_acc == r_held)) |=>
            (r_rsp_vld && (r_rsp.kind == KIND_RELEASED) && r_rsp.last))
        else $error("Release without mode change was not reported.");

endmodule

// ===== hw/rtl/logical_lock_grant_queue_top.sv =====
// ============================================================================
// logical_lock_grant_queue_top: one logical lock with owners and waiters
// A request acquires or releases the lock; each request yields one or more
// results, the last of them flagged.
// ============================================================================
// Usage:
// A request on i_req is taken at a clock edge where start is high and busy
// is low. busy stays high until the last result of that request has been
// issued. Results appear on o_rsp for a single cycle with o_rsp_valid high;
// the receiver cannot stall them and must take each one as it comes.
// An acquire gives its single result from the acquire state, through the
// result register. A release scans the owner table through a memory with
// registered read, in a read step and a check step per owner, then ends the
// scan and settles the mode. If the mode changed, it then reads and checks
// each waiter at the FIFO head in turn, the promoted ones and the one that
// ends promotion. busy is low while the last result is on o_rsp, so the
// next request may be taken at the edge that ends that cycle.
// The compatibility matrix is written through i_cfg_valid / o_cfg_ready /
// i_cfg_data while the block is idle. Reset empties the owner table and the
// waiter FIFO, clears the held mode and loads the matrix reset value.
// ============================================================================
module logical_lock_grant_queue_top
    import llgq_pkg::*;
#(
    parameter int OWNER_DEPTH  = OWNER_DEPTH_DEF,
    parameter int WAITER_DEPTH = WAITER_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  t_req                i_req,
    output logic                o_rsp_valid,
    output t_rsp                o_rsp,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [COMPAT_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;
    logic ctrl_busy;

    llgq_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_op   (i_req.op),
        .i_sts  (sts),
        .o_cmd  (cmd),
        .o_busy (ctrl_busy)
    );

    llgq_dp #(
        .OWNER_DEPTH (OWNER_DEPTH),
        .WAITER_DEPTH(WAITER_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_valid && !ctrl_busy),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_rsp_valid(o_rsp_valid),
        .o_rsp      (o_rsp)
    );

    assign busy        = ctrl_busy;
    assign o_cfg_ready = !ctrl_busy;

endmodule
